[hdl/ssxf_pkg.sv]
// Shared types, constants and slot decode for the status snapshot XOR framer.
`default_nettype none
package ssxf_pkg;

  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 3;
  localparam int VALUE_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 32;

  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

  // writable record bytes 4..13, held as positions 0..9
  localparam int REC_WR    = 10;
  localparam int POS_W     = $clog2(REC_WR);

  localparam int FRAME_LEN = 31;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  // frame layout
  localparam int ID_FIRST  = 5;
  localparam int REC_FIRST = 9;
  localparam int REC_END   = REC_FIRST + REC_WR;  // first always-zero byte
  localparam int CHK_FIRST = 1;
  localparam int CHK_POS   = 29;
  localparam int LAST_POS  = FRAME_LEN - 1;

  localparam logic [BYTE_W-1:0] HDR_SOF   = 8'h5B;
  localparam logic [BYTE_W-1:0] HDR_B1    = 8'hD2;
  localparam logic [BYTE_W-1:0] HDR_B2    = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_B3    = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_LEN   = 8'h18;
  localparam logic [BYTE_W-1:0] FRAME_EOF = 8'h5D;

  localparam int CMDQ_DEPTH = 4;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] field_value;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } out_t;

  typedef enum logic [1:0] {
    CMD_UPDATE,
    CMD_MARK,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [POS_W-1:0]   pos;
    logic               wide;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_head_t;

  // first held position of each slot
  function automatic logic [POS_W-1:0] slot_pos(input logic [SLOT_W-1:0] s);
    logic [POS_W-1:0] p;
    unique case (s)
      3'd0:    p = POS_W'(0);
      3'd1:    p = POS_W'(2);
      3'd2:    p = POS_W'(3);
      3'd3:    p = POS_W'(4);
      3'd4:    p = POS_W'(6);
      3'd5:    p = POS_W'(7);
      3'd6:    p = POS_W'(8);
      default: p = POS_W'(9);
    endcase
    return p;
  endfunction

  function automatic logic slot_wide(input logic [SLOT_W-1:0] s);
    return (s == 3'd0) || (s == 3'd3);
  endfunction

endpackage
`default_nettype wire

[hdl/ssxf_front.sv]
// Front end: takes input transfers and turns them into back-end commands.
`default_nettype none
module ssxf_front (
  input  wire ssxf_pkg::in_t  item,
  input  wire logic           push,
  input  wire logic           q_full,
  output logic                full,
  output logic                q_push,
  output ssxf_pkg::cmd_t      cmd
);

  logic keep;

  always_comb begin
    keep       = 1'b1;
    cmd.kind   = ssxf_pkg::CMD_MARK;
    cmd.pos    = ssxf_pkg::slot_pos(item.slot);
    cmd.wide   = ssxf_pkg::slot_wide(item.slot);
    cmd.value  = item.field_value;
    unique case (item.req_type)
      ssxf_pkg::REQ_UPDATE: cmd.kind = ssxf_pkg::CMD_UPDATE;
      ssxf_pkg::REQ_MARK:   cmd.kind = ssxf_pkg::CMD_MARK;
      ssxf_pkg::REQ_REPORT: cmd.kind = ssxf_pkg::CMD_REPORT;
      default:              keep = 1'b0;  // unused code: dropped
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

endmodule
`default_nettype wire

[hdl/ssxf_cmdq.sv]
// Short command queue between front and back end.
`default_nettype none
module ssxf_cmdq #(
  parameter int DEPTH = ssxf_pkg::CMDQ_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ssxf_pkg::cmd_t       din,
  input  wire logic                 pop,
  output ssxf_pkg::cmdq_head_t      head,
  output logic                      full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ssxf_pkg::cmd_t  slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/ssxf_back.sv]
// Back end: holds the record and changed flag, runs commands, streams frames.
`default_nettype none
module ssxf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ssxf_pkg::ID_W-1:0]     cfg_data,
  input  wire ssxf_pkg::cmdq_head_t          head,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               out_valid,
  output ssxf_pkg::out_t                     result
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t                              state;
  logic [ssxf_pkg::ID_W-1:0]           device_id;
  logic [ssxf_pkg::BYTE_W-1:0]         rec [ssxf_pkg::REC_WR];
  logic                                changed;
  logic [ssxf_pkg::IDX_W-1:0]          idx;
  logic [ssxf_pkg::BYTE_W-1:0]         chk;
  logic [ssxf_pkg::BYTE_W-1:0]         cur_byte;
  logic [ssxf_pkg::IDX_W-1:0]          rec_off;
  logic                                slot_free;
  logic [ssxf_pkg::POS_W-1:0]          pos_lo;

  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == ST_IDLE) && head.valid;
  assign rec_off   = idx - ssxf_pkg::IDX_W'(ssxf_pkg::REC_FIRST);
  assign pos_lo    = head.cmd.pos + 1'b1;

  always_comb begin
    cur_byte = '0;
    if (idx == ssxf_pkg::IDX_W'(0)) begin
      cur_byte = ssxf_pkg::HDR_SOF;
    end else if (idx == ssxf_pkg::IDX_W'(1)) begin
      cur_byte = ssxf_pkg::HDR_B1;
    end else if (idx == ssxf_pkg::IDX_W'(2)) begin
      cur_byte = ssxf_pkg::HDR_B2;
    end else if (idx == ssxf_pkg::IDX_W'(3)) begin
      cur_byte = ssxf_pkg::HDR_B3;
    end else if (idx == ssxf_pkg::IDX_W'(4)) begin
      cur_byte = ssxf_pkg::HDR_LEN;
    end else if (idx < ssxf_pkg::IDX_W'(ssxf_pkg::REC_FIRST)) begin
      // id bytes, most significant first
      case (idx - ssxf_pkg::IDX_W'(ssxf_pkg::ID_FIRST))
        ssxf_pkg::IDX_W'(0): cur_byte = device_id[31:24];
        ssxf_pkg::IDX_W'(1): cur_byte = device_id[23:16];
        ssxf_pkg::IDX_W'(2): cur_byte = device_id[15:8];
        default:             cur_byte = device_id[7:0];
      endcase
    end else if (idx < ssxf_pkg::IDX_W'(ssxf_pkg::REC_END)) begin
      cur_byte = rec[rec_off[ssxf_pkg::POS_W-1:0]];
    end else if (idx == ssxf_pkg::IDX_W'(ssxf_pkg::CHK_POS)) begin
      cur_byte = chk;
    end else if (idx == ssxf_pkg::IDX_W'(ssxf_pkg::LAST_POS)) begin
      cur_byte = ssxf_pkg::FRAME_EOF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= '0;
    end else if (cfg_we) begin
      device_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      changed   <= 1'b1;
      out_valid <= 1'b0;
      idx       <= '0;
      chk       <= '0;
      for (int i = 0; i < ssxf_pkg::REC_WR; i++) begin
        rec[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            out_valid <= 1'b0;
          end
          if (head.valid) begin
            unique case (head.cmd.kind)
              ssxf_pkg::CMD_UPDATE: begin
                changed <= 1'b1;
                if (head.cmd.wide) begin
                  rec[head.cmd.pos] <= head.cmd.value[15:8];
                  rec[pos_lo]       <= head.cmd.value[7:0];
                end else begin
                  rec[head.cmd.pos] <= head.cmd.value[7:0];
                end
              end
              ssxf_pkg::CMD_MARK: changed <= 1'b1;
              ssxf_pkg::CMD_REPORT: begin
                if (changed) begin
                  changed <= 1'b0;
                  idx     <= '0;
                  chk     <= '0;
                  state   <= ST_SEND;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEND: begin
          if (slot_free) begin
            out_valid         <= 1'b1;
            result.frame_byte <= cur_byte;
            result.last_byte  <= (idx == ssxf_pkg::IDX_W'(ssxf_pkg::LAST_POS));
            if (idx >= ssxf_pkg::IDX_W'(ssxf_pkg::CHK_FIRST) &&
                idx <  ssxf_pkg::IDX_W'(ssxf_pkg::CHK_POS)) begin
              chk <= chk ^ cur_byte;
            end
            if (idx == ssxf_pkg::IDX_W'(ssxf_pkg::LAST_POS)) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/status_snapshot_xor_framer_unit.sv]
// Top level of the status snapshot XOR framer: front end, command queue, back end.
// An accepted update or mark is queued, then applied by the back end; a sent report
//   reaches the result ports via the queue, the send state and the output register.
// Throughput: one command per cycle while idle; a sent report holds the back end for
//   31 frame bytes, one per cycle via the single output register unless pop stalls.
// Reset (rst, synchronous): queue empty, record zero, device_id zero, changed set.
`default_nettype none
module status_snapshot_xor_framer_unit #(
  parameter int CMDQ_DEPTH = ssxf_pkg::CMDQ_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input side
  input  wire logic                      push,
  output logic                           full,
  input  wire ssxf_pkg::in_t             item,
  // result side
  output logic                           empty,
  input  wire logic                      pop,
  output ssxf_pkg::out_t                 result,
  // device_id register
  input  wire logic                      cfg_we,
  input  wire logic [ssxf_pkg::ID_W-1:0] cfg_data
);

  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic [CW-1:0]        q_count;
  ssxf_pkg::cmd_t       cmd;
  ssxf_pkg::cmdq_head_t head;
  logic                 out_valid;

  // classify: drops unused request codes, decodes slot placement
  ssxf_front u_front (
    .item   (item),
    .push   (push),
    .q_full (q_full),
    .full   (full),
    .q_push (q_push),
    .cmd    (cmd)
  );

  // lets the front keep taking transfers while a frame drains
  ssxf_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (cmd),
    .pop   (q_pop),
    .head  (head),
    .full  (q_full),
    .count (q_count)
  );

  // executes commands in order; the record only changes between frames
  ssxf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign empty = !out_valid;

  // closing byte of a frame always carries the end marker
  a_last_eof: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last_byte) |-> (result.frame_byte == ssxf_pkg::FRAME_EOF))
    else $error("last byte is not the end marker");

  // full flag tracks the queue fill
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    full == (q_count == CW'(CMDQ_DEPTH)))
    else $error("full flag out of step with queue fill");

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // queue never pops when empty
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("command popped from empty queue");

endmodule
`default_nettype wire
